@@ rtl/aabb_affine_transform_top_defines.svh @@
// Assertion helpers for the box transform top module.
`ifndef AABB_AFFINE_TRANSFORM_TOP_DEFINES_SVH
`define AABB_AFFINE_TRANSFORM_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define AAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define AAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/aat_pkg.sv @@
package aat_pkg;

  // Number of spatial axes
  localparam int AXES = 3;

  // Integer bits of a Q2.x coefficient; the rest are fraction bits
  localparam int COEFF_INT_BITS = 2;

  // Register map: 8-byte stride, index in paddr[5:3]
  localparam int ADDR_W     = 6;
  localparam int ADDR_LSB   = 3;
  localparam int REG_IDX_W  = ADDR_W - ADDR_LSB;

  localparam logic [REG_IDX_W-1:0] REG_ROW_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SHF_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SHF_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SHF_Z = 3'd5;

endpackage

@@ rtl/aat_order.sv @@
// Stage 1: order the two corners of each axis into min and max.
module aat_order #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          ready_up,
  input  logic signed [COORD_WIDTH-1:0] corner_a [aat_pkg::AXES],
  input  logic signed [COORD_WIDTH-1:0] corner_b [aat_pkg::AXES],
  output logic                          valid,
  input  logic                          ready_dn,
  output logic signed [COORD_WIDTH-1:0] lo [aat_pkg::AXES],
  output logic signed [COORD_WIDTH-1:0] hi [aat_pkg::AXES]
);
  import aat_pkg::*;

  assign ready_up = !valid || ready_dn;

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= in_valid;
    end
  end

  // Per-axis compare and swap
  always_ff @(posedge clk) begin
    if (ready_up && in_valid) begin
      for (int i = 0; i < AXES; i++) begin
        if (corner_a[i] < corner_b[i]) begin
          lo[i] <= corner_a[i];
          hi[i] <= corner_b[i];
        end else begin
          lo[i] <= corner_b[i];
          hi[i] <= corner_a[i];
        end
      end
    end
  end

endmodule

@@ rtl/aat_term.sv @@
// Stages 2 and 3: the nine coefficient products at both ends of each input
// range, floor-scaled, then the smaller and larger of each pair. The affine
// map is separable per input axis, so the extreme of a row over all eight
// corners is the sum of per-term extremes.
module aat_term #(
  parameter int COORD_WIDTH = 32,
  parameter int COEFF_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            ready_up,
  input  logic signed [COORD_WIDTH-1:0]   lo [aat_pkg::AXES],
  input  logic signed [COORD_WIDTH-1:0]   hi [aat_pkg::AXES],
  input  logic [3*COEFF_WIDTH-1:0]        rows [aat_pkg::AXES],
  output logic                            valid,
  input  logic                            ready_dn,
  output logic signed [COORD_WIDTH+1:0]   tmin [aat_pkg::AXES][aat_pkg::AXES],
  output logic signed [COORD_WIDTH+1:0]   tmax [aat_pkg::AXES][aat_pkg::AXES]
);
  import aat_pkg::*;

  localparam int FRAC = COEFF_WIDTH - COEFF_INT_BITS;
  localparam int PW   = COORD_WIDTH + COEFF_WIDTH;
  localparam int TW   = COORD_WIDTH + 2;

  logic                  p_valid;
  logic                  p_ready;
  logic                  t3_ready;
  logic signed [PW-1:0]  full_lo [AXES][AXES];
  logic signed [PW-1:0]  full_hi [AXES][AXES];
  logic signed [TW-1:0]  prod_lo [AXES][AXES];
  logic signed [TW-1:0]  prod_hi [AXES][AXES];

  assign t3_ready = !valid || ready_dn;
  assign p_ready  = !p_valid || t3_ready;
  assign ready_up = p_ready;

  // Full products, row j (output axis) by column i (input axis)
  always_comb begin
    for (int j = 0; j < AXES; j++) begin
      for (int i = 0; i < AXES; i++) begin
        full_lo[j][i] = lo[i] * $signed(rows[j][i*COEFF_WIDTH +: COEFF_WIDTH]);
        full_hi[j][i] = hi[i] * $signed(rows[j][i*COEFF_WIDTH +: COEFF_WIDTH]);
      end
    end
  end

  // Stage 2: floor shift by dropping the fraction bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_ready) begin
      p_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && in_valid) begin
      for (int j = 0; j < AXES; j++) begin
        for (int i = 0; i < AXES; i++) begin
          prod_lo[j][i] <= full_lo[j][i][PW-1:FRAC];
          prod_hi[j][i] <= full_hi[j][i][PW-1:FRAC];
        end
      end
    end
  end

  // Stage 3: per-term min and max
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (t3_ready) begin
      valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (t3_ready && p_valid) begin
      for (int j = 0; j < AXES; j++) begin
        for (int i = 0; i < AXES; i++) begin
          if (prod_lo[j][i] < prod_hi[j][i]) begin
            tmin[j][i] <= prod_lo[j][i];
            tmax[j][i] <= prod_hi[j][i];
          end else begin
            tmin[j][i] <= prod_hi[j][i];
            tmax[j][i] <= prod_lo[j][i];
          end
        end
      end
    end
  end

endmodule

@@ rtl/aat_sum.sv @@
// Stages 4 and 5: add the translation and three terms, then saturate.
module aat_sum #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          ready_up,
  input  logic signed [COORD_WIDTH+1:0] tmin [aat_pkg::AXES][aat_pkg::AXES],
  input  logic signed [COORD_WIDTH+1:0] tmax [aat_pkg::AXES][aat_pkg::AXES],
  input  logic [COORD_WIDTH-1:0]        shifts [aat_pkg::AXES],
  output logic                          valid,
  input  logic                          ready_dn,
  output logic signed [COORD_WIDTH-1:0] box_lo [aat_pkg::AXES],
  output logic signed [COORD_WIDTH-1:0] box_hi [aat_pkg::AXES]
);
  import aat_pkg::*;

  localparam int SW = COORD_WIDTH + 4;
  localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic                 s_valid;
  logic                 s_ready;
  logic                 o_ready;
  logic signed [SW-1:0] sum_lo_next [AXES];
  logic signed [SW-1:0] sum_hi_next [AXES];
  logic signed [SW-1:0] sum_lo [AXES];
  logic signed [SW-1:0] sum_hi [AXES];

  assign o_ready  = !valid || ready_dn;
  assign s_ready  = !s_valid || o_ready;
  assign ready_up = s_ready;

  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
    logic [SW-COORD_WIDTH:0] top;
    top = v[SW-1:COORD_WIDTH-1];
    if (top == '0 || top == '1) begin
      return v[COORD_WIDTH-1:0];
    end
    return v[SW-1] ? SAT_MIN : SAT_MAX;
  endfunction

  // Four-input sums per output axis
  always_comb begin
    for (int j = 0; j < AXES; j++) begin
      sum_lo_next[j] = SW'($signed(shifts[j])) + SW'(tmin[j][0]) + SW'(tmin[j][1])
                     + SW'(tmin[j][2]);
      sum_hi_next[j] = SW'($signed(shifts[j])) + SW'(tmax[j][0]) + SW'(tmax[j][1])
                     + SW'(tmax[j][2]);
    end
  end

  // Stage 4
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (s_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && in_valid) begin
      sum_lo <= sum_lo_next;
      sum_hi <= sum_hi_next;
    end
  end

  // Stage 5: saturate into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (o_ready) begin
      valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && s_valid) begin
      for (int j = 0; j < AXES; j++) begin
        box_lo[j] <= sat(sum_lo[j]);
        box_hi[j] <= sat(sum_hi[j]);
      end
    end
  end

endmodule

@@ rtl/aabb_affine_transform_top.sv @@
// Channel | direction | handshake              | payload
// in      | request   | in_valid / in_stall    | corner_a_{x,y,z}, corner_b_{x,y,z}
// out     | result    | out_valid / out_stall  | low_{x,y,z}, high_{x,y,z}
// cfg     | APB write | psel, penable, pwrite  | paddr[5:3] register, pwdata
//
// One request per cycle sustained while out_stall is low; the result passes through
// the register stages in order (order, product, min/max, sum, saturate).
// Each stage holds while the one after it is full and stalled; bubbles close up.
// in_stall is high only when every stage is full and out_stall is high.
// Synchronous reset clears all valid bits and loads the identity transform.
module aabb_affine_transform_top #(
  parameter int COORD_WIDTH = 32,
  parameter int COEFF_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // Request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] corner_a_x,
  input  logic signed [COORD_WIDTH-1:0] corner_a_y,
  input  logic signed [COORD_WIDTH-1:0] corner_a_z,
  input  logic signed [COORD_WIDTH-1:0] corner_b_x,
  input  logic signed [COORD_WIDTH-1:0] corner_b_y,
  input  logic signed [COORD_WIDTH-1:0] corner_b_z,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] low_x,
  output logic signed [COORD_WIDTH-1:0] low_y,
  output logic signed [COORD_WIDTH-1:0] low_z,
  output logic signed [COORD_WIDTH-1:0] high_x,
  output logic signed [COORD_WIDTH-1:0] high_y,
  output logic signed [COORD_WIDTH-1:0] high_z,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aat_pkg::ADDR_W-1:0]    paddr,
  input  logic [((3*COEFF_WIDTH > 64) ? 3*COEFF_WIDTH : 64)-1:0] pwdata,
  output logic [((3*COEFF_WIDTH > 64) ? 3*COEFF_WIDTH : 64)-1:0] prdata,
  output logic                          pready
);
  import aat_pkg::*;

  `include "aabb_affine_transform_top_defines.svh"

  localparam int ROW_W  = 3 * COEFF_WIDTH;
  localparam int DATA_W = (ROW_W > 64) ? ROW_W : 64;
  localparam int FRAC   = COEFF_WIDTH - COEFF_INT_BITS;

  localparam logic [ROW_W-1:0] ROW_X_RST = ROW_W'(1) << FRAC;
  localparam logic [ROW_W-1:0] ROW_Y_RST = ROW_W'(1) << (FRAC + COEFF_WIDTH);
  localparam logic [ROW_W-1:0] ROW_Z_RST = ROW_W'(1) << (FRAC + 2 * COEFF_WIDTH);

  logic [ROW_W-1:0]        row_x;
  logic [ROW_W-1:0]        row_y;
  logic [ROW_W-1:0]        row_z;
  logic [COORD_WIDTH-1:0]  shift_x;
  logic [COORD_WIDTH-1:0]  shift_y;
  logic [COORD_WIDTH-1:0]  shift_z;
  logic                    cfg_wr;
  logic [REG_IDX_W-1:0]    reg_idx;

  logic                          ord_ready;
  logic                          ord_valid;
  logic                          term_ready;
  logic                          term_valid;
  logic                          sum_ready;
  logic signed [COORD_WIDTH-1:0] corner_a [AXES];
  logic signed [COORD_WIDTH-1:0] corner_b [AXES];
  logic signed [COORD_WIDTH-1:0] ord_lo [AXES];
  logic signed [COORD_WIDTH-1:0] ord_hi [AXES];
  logic [ROW_W-1:0]              rows [AXES];
  logic [COORD_WIDTH-1:0]        shifts [AXES];
  logic signed [COORD_WIDTH+1:0] tmin [AXES][AXES];
  logic signed [COORD_WIDTH+1:0] tmax [AXES][AXES];
  logic signed [COORD_WIDTH-1:0] box_lo [AXES];
  logic signed [COORD_WIDTH-1:0] box_hi [AXES];

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:ADDR_LSB];

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x   <= ROW_X_RST;
      row_y   <= ROW_Y_RST;
      row_z   <= ROW_Z_RST;
      shift_x <= '0;
      shift_y <= '0;
      shift_z <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ROW_X: row_x   <= pwdata[ROW_W-1:0];
        REG_ROW_Y: row_y   <= pwdata[ROW_W-1:0];
        REG_ROW_Z: row_z   <= pwdata[ROW_W-1:0];
        REG_SHF_X: shift_x <= pwdata[COORD_WIDTH-1:0];
        REG_SHF_Y: shift_y <= pwdata[COORD_WIDTH-1:0];
        REG_SHF_Z: shift_z <= pwdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_ROW_X: prdata = DATA_W'(row_x);
      REG_ROW_Y: prdata = DATA_W'(row_y);
      REG_ROW_Z: prdata = DATA_W'(row_z);
      REG_SHF_X: prdata = DATA_W'(shift_x);
      REG_SHF_Y: prdata = DATA_W'(shift_y);
      REG_SHF_Z: prdata = DATA_W'(shift_z);
      default:   prdata = '0;
    endcase
  end

  // Gather per-axis vectors
  assign corner_a = '{corner_a_x, corner_a_y, corner_a_z};
  assign corner_b = '{corner_b_x, corner_b_y, corner_b_z};
  assign rows     = '{row_x, row_y, row_z};
  assign shifts   = '{shift_x, shift_y, shift_z};

  assign in_stall = !ord_ready;

  aat_order #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_order (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .ready_up (ord_ready),
    .corner_a (corner_a),
    .corner_b (corner_b),
    .valid    (ord_valid),
    .ready_dn (term_ready),
    .lo       (ord_lo),
    .hi       (ord_hi)
  );

  aat_term #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEFF_WIDTH (COEFF_WIDTH)
  ) u_term (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ord_valid),
    .ready_up (term_ready),
    .lo       (ord_lo),
    .hi       (ord_hi),
    .rows     (rows),
    .valid    (term_valid),
    .ready_dn (sum_ready),
    .tmin     (tmin),
    .tmax     (tmax)
  );

  aat_sum #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_sum (
    .clk      (clk),
    .rst      (rst),
    .in_valid (term_valid),
    .ready_up (sum_ready),
    .tmin     (tmin),
    .tmax     (tmax),
    .shifts   (shifts),
    .valid    (out_valid),
    .ready_dn (!out_stall),
    .box_lo   (box_lo),
    .box_hi   (box_hi)
  );

  assign low_x  = box_lo[0];
  assign low_y  = box_lo[1];
  assign low_z  = box_lo[2];
  assign high_x = box_hi[0];
  assign high_y = box_hi[1];
  assign high_z = box_hi[2];

  // Checks
  `AAT_ASSERT_NOW(a_box_ordered, out_valid,
    (low_x <= high_x) && (low_y <= high_y) && (low_z <= high_z),
    "result box has low above high")
  `AAT_ASSERT_NOW(a_stall_only_full, in_stall,
    ord_valid && term_valid && out_valid && out_stall,
    "request stalled while pipeline has room")
  `AAT_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, ord_valid,
    "accepted request missing from first stage")

endmodule

@@ tb/sv/tb_aabb_affine_transform_top.sv @@
module tb_aabb_affine_transform_top;
  import aat_pkg::*;

  localparam int COORD_W = 32;
  localparam int COEFF_W = 16;
  localparam int ROW_W = 3 * COEFF_W;
  localparam int COEFF_FRAC = COEFF_W - COEFF_INT_BITS;
  localparam int LATENCY = 5;
  localparam int IDLE_PCT = 35;
  localparam int NUM_PHASES = 11;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int STEADY_PHASE = 5;
  localparam int NUM_DIRECTED = 29;
  localparam int MAX_REPORTS = 40;
  localparam int FINAL_LIMIT = 100000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [0:2] vec3_t;
  typedef struct packed {
    vec3_t lo;
    vec3_t hi;
  } box_t;

  typedef enum logic {ROW_BOX, ROW_WRITE} row_kind_e;
  typedef struct packed {
    row_kind_e kind;
    logic typed;
    logic [REG_IDX_W-1:0] idx;
    logic [63:0] value;
    vec3_t a;
    vec3_t b;
    box_t want;
  } stim_row_t;

  // Register indexes past the end of the map; writes there are dropped
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam logic [REG_IDX_W-1:0] ROW_REGS [3] = '{REG_ROW_X, REG_ROW_Y, REG_ROW_Z};
  localparam logic [REG_IDX_W-1:0] SHIFT_REGS [3] = '{REG_SHF_X, REG_SHF_Y, REG_SHF_Z};

  localparam logic [COEFF_W-1:0] ID_COEFF = 16'h4000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  // Q16.16 values used by the directed table
  localparam coord_t COORD_MAX = 32'h7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'h8000_0000;
  localparam coord_t ZERO = 32'h0;
  localparam coord_t F1 = 32'h0001_0000;
  localparam coord_t F2 = 32'h0002_0000;
  localparam coord_t F3 = 32'h0003_0000;
  localparam coord_t F4 = 32'h0004_0000;
  localparam coord_t F5 = 32'h0005_0000;
  localparam coord_t F6 = 32'h0006_0000;
  localparam coord_t NEG_ONE = 32'hFFFF_0000;
  localparam coord_t M75 = 32'hFFF8_8000;
  localparam coord_t TINY_P = 32'h0000_0001;
  localparam coord_t TINY_N = 32'hFFFF_FFFF;
  localparam coord_t TINY_P3 = 32'h0000_0003;
  localparam coord_t TINY_N3 = 32'hFFFF_FFFD;
  localparam vec3_t MAX3 = {COORD_MAX, COORD_MAX, COORD_MAX};
  localparam vec3_t MIN3 = {COORD_MIN, COORD_MIN, COORD_MIN};

  logic clk;
  logic rst = 1'b1;
  logic in_valid;
  logic in_stall;
  coord_t corner_a_x, corner_a_y, corner_a_z;
  coord_t corner_b_x, corner_b_y, corner_b_z;
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t low_x, low_y, low_z, high_x, high_y, high_z;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  // Shadow copy of the transform registers
  logic [ROW_W-1:0] row_cfg [3];
  coord_t shift_cfg [3];

  box_t expected_boxes [$];
  stim_row_t directed_rows [NUM_DIRECTED];
  string axis_names [3] = '{"x", "y", "z"};
  bit steady = 1'b0;
  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int write_count = 0;

  aabb_affine_transform_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .corner_a_x(corner_a_x),
    .corner_a_y(corner_a_y),
    .corner_a_z(corner_a_z),
    .corner_b_x(corner_b_x),
    .corner_b_y(corner_b_y),
    .corner_b_z(corner_b_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .low_x(low_x),
    .low_y(low_y),
    .low_z(low_z),
    .high_x(high_x),
    .high_y(high_y),
    .high_z(high_z),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("[aabb_affine_transform_top] ERROR");
    $finish;
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // One output axis of one corner: floor-shifted products plus offset, saturated
  function automatic coord_t map_axis(input logic [ROW_W-1:0] row, input coord_t offset,
                                      input vec3_t p);
    longint acc;
    coord_t c;
    logic signed [COEFF_W-1:0] k;
    acc = longint'(offset);
    for (int i = 0; i < 3; i++) begin
      c = p[i];
      k = row[COEFF_W*i +: COEFF_W];
      acc += (longint'(c) * longint'(k)) >>> COEFF_FRAC;
    end
    if (acc > SAT_HI) return COORD_MAX;
    if (acc < SAT_LO) return COORD_MIN;
    return coord_t'(acc);
  endfunction

  // Box after the transform: order corners, map all eight, take per-axis bounds
  function automatic box_t predict_box(input vec3_t a, input vec3_t b);
    coord_t lo [3], hi [3], mn [3], mx [3];
    coord_t ca, cb, q;
    vec3_t p;
    box_t r;
    for (int ax = 0; ax < 3; ax++) begin
      ca = a[ax];
      cb = b[ax];
      lo[ax] = (ca < cb) ? ca : cb;
      hi[ax] = (ca < cb) ? cb : ca;
    end
    for (int c = 0; c < 8; c++) begin
      for (int ax = 0; ax < 3; ax++) p[ax] = c[ax] ? hi[ax] : lo[ax];
      for (int ax = 0; ax < 3; ax++) begin
        q = map_axis(row_cfg[ax], shift_cfg[ax], p);
        if (c == 0 || q < mn[ax]) mn[ax] = q;
        if (c == 0 || q > mx[ax]) mx[ax] = q;
      end
    end
    for (int ax = 0; ax < 3; ax++) begin
      r.lo[ax] = mn[ax];
      r.hi[ax] = mx[ax];
    end
    return r;
  endfunction

  function automatic stim_row_t typed_row(input vec3_t a, input vec3_t b,
                                          input vec3_t lo, input vec3_t hi);
    return '{ROW_BOX, 1'b1, REG_ROW_X, 64'd0, a, b, {lo, hi}};
  endfunction

  function automatic stim_row_t box_row(input vec3_t a, input vec3_t b);
    return '{ROW_BOX, 1'b0, REG_ROW_X, 64'd0, a, b, '0};
  endfunction

  function automatic stim_row_t write_row(input logic [REG_IDX_W-1:0] idx,
                                          input logic [63:0] value);
    return '{ROW_WRITE, 1'b0, idx, value, '0, '0, '0};
  endfunction

  function automatic logic [COEFF_W-1:0] random_coeff();
    case ($urandom_range(0, 7))
      0: return ID_COEFF;
      1: return 16'hC000;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'h0000;
      default: return COEFF_W'($urandom);
    endcase
  endfunction

  function automatic coord_t random_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return ZERO;
      3, 4, 5: return coord_t'($urandom);
      default: return coord_t'($urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000);
    endcase
  endfunction

  // APB write: setup then access, register lands on the access edge
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, {ADDR_LSB{1'b0}}};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ROW_X: row_cfg[0] = value[ROW_W-1:0];
      REG_ROW_Y: row_cfg[1] = value[ROW_W-1:0];
      REG_ROW_Z: row_cfg[2] = value[ROW_W-1:0];
      REG_SHF_X: shift_cfg[0] = value[COORD_W-1:0];
      REG_SHF_Y: shift_cfg[1] = value[COORD_W-1:0];
      REG_SHF_Z: shift_cfg[2] = value[COORD_W-1:0];
      default: ;
    endcase
    write_count++;
    @(posedge clk);
  endtask

  // Hold requests until the pipeline has emptied
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
  endtask

  // Send one request; valid stays up across back-to-back requests
  task automatic send_box(input vec3_t a, input vec3_t b, input logic typed,
                          input box_t want);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    corner_a_x <= a[0];
    corner_a_y <= a[1];
    corner_a_z <= a[2];
    corner_b_x <= b[0];
    corner_b_y <= b[1];
    corner_b_z <= b[2];
    do @(posedge clk); while (in_stall);
    expected_boxes.push_back(typed ? want : predict_box(a, b));
    sent_count++;
  endtask

  // Result side back-pressure
  always @(posedge clk) begin
    out_stall <= !rst && !steady && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Result checker
  always @(posedge clk) begin : check_results
    box_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {{low_x, low_y, low_z}, {high_x, high_y, high_z}};
      if (expected_boxes.size() == 0) begin
        flag_error("result with no request pending");
      end else begin
        want = expected_boxes.pop_front();
        checked_count++;
        for (int i = 0; i < 3; i++) begin
          if (got.lo[i] !== want.lo[i])
            flag_error($sformatf("low_%s got %h want %h", axis_names[i], got.lo[i],
                                 want.lo[i]));
          if (got.hi[i] !== want.hi[i])
            flag_error($sformatf("high_%s got %h want %h", axis_names[i], got.hi[i],
                                 want.hi[i]));
        end
      end
    end
  end

  initial begin : stimulus
    vec3_t a, b;
    logic [63:0] value;
    int pick;
    int guard;
    in_valid <= 1'b0;
    corner_a_x <= '0;
    corner_a_y <= '0;
    corner_a_z <= '0;
    corner_b_x <= '0;
    corner_b_y <= '0;
    corner_b_z <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    for (int r = 0; r < 3; r++) begin
      row_cfg[r] = ROW_W'(ID_COEFF) << (COEFF_W * r);
      shift_cfg[r] = ZERO;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: identity after reset, saturation, floor rounding, dropped writes
    directed_rows = '{
      typed_row({F1, F2, F3}, {F4, F5, F6}, {F1, F2, F3}, {F4, F5, F6}),
      typed_row({F4, F5, F6}, {F1, F2, F3}, {F1, F2, F3}, {F4, F5, F6}),
      typed_row({F1, F5, F3}, {F4, F2, F6}, {F1, F2, F3}, {F4, F5, F6}),
      typed_row({M75, F2, COORD_MIN}, {M75, F2, COORD_MIN},
                {M75, F2, COORD_MIN}, {M75, F2, COORD_MIN}),
      typed_row(MAX3, MIN3, MIN3, MAX3),
      typed_row({COORD_MIN, COORD_MAX, COORD_MIN}, {COORD_MAX, COORD_MIN, COORD_MAX},
                MIN3, MAX3),
      typed_row({TINY_P, TINY_N, ZERO}, {TINY_N, TINY_P, ZERO},
                {TINY_N, TINY_N, ZERO}, {TINY_P, TINY_P, ZERO}),
      write_row(REG_ROW_X, 64'h0000_7FFF_7FFF_7FFF),
      write_row(REG_ROW_Y, 64'h0000_8000_8000_8000),
      write_row(REG_ROW_Z, 64'h0),
      write_row(REG_SHF_X, {32'h0, COORD_MAX}),
      write_row(REG_SHF_Y, {32'h0, COORD_MIN}),
      write_row(REG_SHF_Z, 64'hFFFF_FFFF_0000_0000),
      box_row(MAX3, MIN3),
      box_row({F1, F2, F3}, {F4, F5, F6}),
      box_row(MAX3, MAX3),
      write_row(REG_ROW_X, 64'h0000_0000_0000_2000),
      write_row(REG_ROW_Y, 64'h0000_0000_E000_0000),
      write_row(REG_ROW_Z, 64'h0000_C000_0000_0000),
      write_row(REG_SHF_Y, {32'h0, F1}),
      write_row(REG_SHF_Z, {32'hFFFF_FFFF, NEG_ONE}),
      write_row(REG_SHF_X, 64'h0),
      box_row({TINY_N3, TINY_P3, TINY_P}, {TINY_N, TINY_N3, COORD_MIN}),
      box_row({TINY_N, TINY_P, COORD_MAX}, {TINY_P, TINY_N, ZERO}),
      write_row(REG_SPARE_A, 64'h0123_4567_89AB_CDEF),
      write_row(REG_SPARE_B, '1),
      box_row({F1, M75, F6}, {M75, F3, F2}),
      write_row(REG_ROW_Y, 64'hFFFF_0000_4000_0000),
      box_row({F2, F4, F6}, {M75, M75, M75})
    };
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        send_box(directed_rows[i].a, directed_rows[i].b, directed_rows[i].typed,
                 directed_rows[i].want);
      end
    end

    // Random phases, each under its own transform
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      steady = (ph == STEADY_PHASE);
      for (int r = 0; r < 3; r++) begin
        case (ph)
          0: value = 64'(ID_COEFF) << (COEFF_W * r);
          1: value = {16'hFFFF, {3{16'h7FFF}}};
          2: value = {16'h0000, {3{16'h8000}}};
          default: value = {16'($urandom), random_coeff(), random_coeff(), random_coeff()};
        endcase
        write_reg(ROW_REGS[r], value);
        pick = $urandom_range(0, 4);
        case (ph)
          0: value = '0;
          1: value = {32'h0, COORD_MAX};
          2: value = {32'hFFFF_FFFF, COORD_MIN};
          default: begin
            case (pick)
              0: value = {$urandom, ZERO};
              1: value = {$urandom, COORD_MAX};
              2: value = {$urandom, COORD_MIN};
              3: value = {$urandom, $urandom};
              default: value = {$urandom, random_coord()};
            endcase
          end
        endcase
        write_reg(SHIFT_REGS[r], value);
      end
      if (ph % 3 == 1) write_reg((ph % 2) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
      repeat (ITEMS_PER_PHASE) begin
        for (int ax = 0; ax < 3; ax++) begin
          a[ax] = random_coord();
          b[ax] = ($urandom_range(0, 9) == 0) ? a[ax] : random_coord();
        end
        send_box(a, b, 1'b0, '0);
      end
    end
    steady = 1'b0;

    // Drain and settle
    in_valid <= 1'b0;
    guard = 0;
    while (expected_boxes.size() != 0 && guard < FINAL_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (2 * LATENCY) @(posedge clk);
    if (expected_boxes.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_boxes.size()));

    $display("Sent %0d boxes (%0d directed rows, %0d random phases), checked %0d results",
             sent_count, NUM_DIRECTED, NUM_PHASES, checked_count);
    $display("Register writes: %0d, including dropped writes past the map", write_count);
    if (error_count == 0) begin
      $display("[aabb_affine_transform_top] OK");
    end else begin
      $display("[aabb_affine_transform_top] ERROR");
    end
    $finish;
  end

endmodule
